// ----- hw/rtl/ict_pkg.sv -----
`timescale 1ns / 1ps

package ict_pkg;

  // Result codes
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Characters with a special role
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int MAX_RESULTS         = 3;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_DONE  = 3'd2,
    MODE_COLON = 3'd3,
    MODE_SLASH = 3'd4,
    MODE_SKIP  = 3'd5,
    MODE_STR   = 3'd6,
    MODE_ESC   = 3'd7
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // All results caused by one input character
  typedef struct packed {
    logic [1:0]                        count;
    out_item_t [MAX_RESULTS-1:0]       items;
  } bundle_t;

endpackage

// ----- hw/rtl/ict_front.sv -----
`timescale 1ns / 1ps

module ict_front import ict_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     push_valid,
  input  logic     push_ready,
  output bundle_t  push_data
);

  lex_mode_t  lex_mode, lex_mode_next;
  logic [7:0] open_quote, open_quote_next;

  // first-byte classification
  logic       st_emit;
  logic [1:0] st_kind;
  lex_mode_t  st_mode;
  logic       st_oq_wr;
  logic [7:0] st_oq;

  logic       pre_cnt_unused;
  logic [1:0] pre_cnt;
  out_item_t  pre0, pre1;
  logic       use_start;
  out_item_t [MAX_RESULTS-1:0] items;
  logic [1:0] count;
  logic [7:0] c;
  logic       is_word;
  logic       is_punct;

  assign c = in_item.ch;
  assign pre_cnt_unused = 1'b0;

  always_comb begin
    is_word = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
    case (c) inside
      8'h2A, 8'h3B, 8'h2C, 8'h2E, 8'h3D, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
      8'h3E, 8'h3C, 8'h28, 8'h29, 8'h2B, 8'h26, 8'h7C, 8'h21, 8'h2D:
        is_punct = 1'b1;
      default:
        is_punct = 1'b0;
    endcase
  end

  always_comb begin
    st_emit  = 1'b0;
    st_kind  = KIND_CHAR;
    st_mode  = MODE_IDLE;
    st_oq_wr = 1'b0;
    st_oq    = c;
    if (is_word || (c == CH_HASH)) begin
      st_emit = 1'b1;
      st_mode = MODE_WORD;
    end else if (is_punct) begin
      st_emit = 1'b1;
      st_mode = MODE_DONE;
    end else if (c == CH_COLON) begin
      st_emit = 1'b1;
      st_mode = MODE_COLON;
    end else if (c == CH_BSLASH) begin
      st_oq_wr = 1'b1;
      st_mode  = MODE_SKIP;
    end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      st_emit  = 1'b1;
      st_oq_wr = 1'b1;
      st_mode  = MODE_STR;
    end else if (c == CH_SLASH) begin
      st_mode = MODE_SLASH;
    end else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
                 (c == CH_NUL)) begin
      st_mode = MODE_IDLE;
    end else begin
      st_emit = 1'b1;
      st_kind = KIND_ERR;
    end
  end

  // per-mode decode: results ahead of the restart, then the restart itself
  always_comb begin
    lex_mode_next   = lex_mode;
    open_quote_next = open_quote;
    pre_cnt         = 2'd0;
    pre0            = '{kind: KIND_END, value: 8'h00, last: 1'b0};
    pre1            = '{kind: KIND_END, value: 8'h00, last: 1'b0};
    use_start       = 1'b0;
    if (in_item.end_of_input) begin
      if (lex_mode == MODE_SLASH) begin
        pre_cnt = 2'd2;
        pre0    = '{kind: KIND_CHAR, value: CH_SLASH, last: 1'b0};
      end else if ((lex_mode != MODE_IDLE) && (lex_mode != MODE_SKIP)) begin
        pre_cnt = 2'd1;
      end
      lex_mode_next   = MODE_IDLE;
      open_quote_next = 8'h00;
    end else begin
      unique case (lex_mode)
        MODE_WORD: begin
          pre_cnt = 2'd1;
          if (is_word) begin
            pre0 = '{kind: KIND_CHAR, value: c, last: 1'b0};
          end else begin
            use_start = 1'b1;
          end
        end
        MODE_DONE: begin
          pre_cnt   = 2'd1;
          use_start = 1'b1;
        end
        MODE_COLON: begin
          pre_cnt = 2'd1;
          if (c == CH_COLON) begin
            pre0          = '{kind: KIND_CHAR, value: c, last: 1'b0};
            lex_mode_next = MODE_DONE;
          end else begin
            use_start = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            open_quote_next = CH_SLASH;
            lex_mode_next   = MODE_SKIP;
          end else begin
            pre_cnt   = 2'd2;
            pre0      = '{kind: KIND_CHAR, value: CH_SLASH, last: 1'b0};
            use_start = 1'b1;
          end
        end
        MODE_SKIP: begin
          if ((c == CH_CR) || (c == CH_LF) || ((c == CH_NUL) && (open_quote == CH_BSLASH))) begin
            lex_mode_next   = MODE_IDLE;
            open_quote_next = 8'h00;
          end
        end
        MODE_STR: begin
          if (c == CH_BSLASH) begin
            lex_mode_next = MODE_ESC;
          end else begin
            pre_cnt = 2'd1;
            pre0    = '{kind: KIND_CHAR, value: c, last: 1'b0};
            if (c == open_quote) begin
              lex_mode_next   = MODE_DONE;
              open_quote_next = 8'h00;
            end
          end
        end
        MODE_ESC: begin
          pre_cnt       = 2'd1;
          pre0          = '{kind: KIND_CHAR, value: c, last: 1'b0};
          lex_mode_next = MODE_STR;
        end
        default: begin
          use_start = 1'b1;
        end
      endcase
      if (use_start) begin
        lex_mode_next = st_mode;
        if (st_oq_wr) begin
          open_quote_next = st_oq;
        end
      end
    end
  end

  // pack results in order, flag the final one
  always_comb begin
    items    = '0;
    items[0] = pre0;
    items[1] = pre1;
    count    = pre_cnt;
    if (use_start && st_emit) begin
      items[pre_cnt] = '{kind: st_kind, value: c, last: 1'b0};
      count          = pre_cnt + 2'd1;
    end
    if (count != 2'd0) begin
      items[count - 2'd1].last = ~pre_cnt_unused;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && (count != 2'd0);
  assign push_data  = '{count: count, items: items};

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode   <= MODE_IDLE;
      open_quote <= 8'h00;
    end else if (in_valid && in_ready) begin
      lex_mode   <= lex_mode_next;
      open_quote <= open_quote_next;
    end
  end

endmodule

// ----- hw/rtl/ict_queue.sv -----
`timescale 1ns / 1ps

module ict_queue import ict_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  bundle_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output bundle_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/ict_back.sv -----
`timescale 1ns / 1ps

module ict_back import ict_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  bundle_t   pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_last;

  assign at_last   = (idx == (cur.count - 2'd1));
  assign out_valid = cur_valid;
  assign out_item  = cur.items[idx];
  assign pop_ready = !cur_valid || (out_ready && at_last);

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx       <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ----- hw/rtl/idl_char_tokenizer.sv -----
`timescale 1ns / 1ps

// Character-serial tokenizer for C-style interface text. One byte is taken
// per input transfer (end_of_input set flushes a pending token, ch ignored)
// and zero to three result transfers come out: token characters, end-of-token
// markers and error reports for unexpected bytes, with last marking the final
// result caused by that byte. The front end takes a new byte every cycle while
// the result queue has room; the output side sends one result per cycle while
// the receiver is ready, so a byte that causes several results can make the
// queue fill and hold the input back. Bytes that cause no result never
// enter the queue. QUEUE_DEPTH sets how many bytes' worth of results may wait
// between the two sides.

module idl_char_tokenizer import ict_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // front end to queue
  logic    push_valid, push_ready;
  bundle_t push_data;

  // queue to serializer
  logic    pop_valid, pop_ready;
  bundle_t pop_data;

  // Lexer state machine: classifies each byte and produces its whole result
  // bundle in the transfer cycle.
  ict_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouples lexing from the output handshake.
  ict_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Unpacks a bundle into single result transfers from a held register.
  ict_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- tb/ict_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the results of every
// accepted byte and compares each result transfer with the oldest prediction.
module ict_checker import ict_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding,
  output int        results_seen
);

  lex_mode_t  mode;
  logic [7:0] quote;
  out_item_t  step_results[$];
  out_item_t  expected_results[$];
  int         mismatches;
  int         checked;

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_UNDER;
  endfunction

  function automatic bit is_mark(logic [7:0] c);
    case (c)
      "*", ";", ",", ".", "=", "{", "}", "[", "]", ">", "<", "(", ")", "+",
      "&", "|", "!", "-": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(logic [1:0] k, logic [7:0] v);
    out_item_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    step_results.push_back(r);
  endtask

  // First byte of a new token, seen from the idle state or after a token ends
  task automatic lex_start(logic [7:0] c);
    if (is_word_char(c) || c == CH_HASH) begin
      emit(KIND_CHAR, c);
      mode = MODE_WORD;
    end else if (is_mark(c)) begin
      emit(KIND_CHAR, c);
      mode = MODE_DONE;
    end else if (c == CH_COLON) begin
      emit(KIND_CHAR, c);
      mode = MODE_COLON;
    end else if (c == CH_BSLASH) begin
      quote = CH_BSLASH;
      mode  = MODE_SKIP;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      emit(KIND_CHAR, c);
      quote = c;
      mode  = MODE_STR;
    end else if (c == CH_SLASH) begin
      mode = MODE_SLASH;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
                 c == CH_NUL) begin
      mode = MODE_IDLE;
    end else begin
      emit(KIND_ERR, c);
      mode = MODE_IDLE;
    end
  endtask

  task automatic lex_predict(in_item_t it);
    logic [7:0] c;
    out_item_t  r;
    c = it.ch;
    step_results.delete();
    if (it.end_of_input) begin
      if (mode == MODE_SLASH) begin
        emit(KIND_CHAR, CH_SLASH);
        emit(KIND_END, 8'h00);
      end else if (mode != MODE_IDLE && mode != MODE_SKIP) begin
        emit(KIND_END, 8'h00);
      end
      mode  = MODE_IDLE;
      quote = 8'h00;
    end else begin
      case (mode)
        MODE_WORD: begin
          if (is_word_char(c)) begin
            emit(KIND_CHAR, c);
          end else begin
            emit(KIND_END, 8'h00);
            lex_start(c);
          end
        end
        MODE_DONE: begin
          emit(KIND_END, 8'h00);
          lex_start(c);
        end
        MODE_COLON: begin
          if (c == CH_COLON) begin
            emit(KIND_CHAR, c);
            mode = MODE_DONE;
          end else begin
            emit(KIND_END, 8'h00);
            lex_start(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            quote = CH_SLASH;
            mode  = MODE_SKIP;
          end else begin
            emit(KIND_CHAR, CH_SLASH);
            emit(KIND_END, 8'h00);
            lex_start(c);
          end
        end
        MODE_SKIP: begin
          // a zero byte ends only a backslash skip, not a line comment
          if (c == CH_CR || c == CH_LF || (c == CH_NUL && quote == CH_BSLASH)) begin
            mode  = MODE_IDLE;
            quote = 8'h00;
          end
        end
        MODE_STR: begin
          if (c == CH_BSLASH) begin
            mode = MODE_ESC;
          end else begin
            emit(KIND_CHAR, c);
            if (c == quote) begin
              mode  = MODE_DONE;
              quote = 8'h00;
            end
          end
        end
        MODE_ESC: begin
          emit(KIND_CHAR, c);
          mode = MODE_STR;
        end
        default: lex_start(c);
      endcase
    end
    foreach (step_results[i]) begin
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
             checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mode  = MODE_IDLE;
      quote = 8'h00;
      expected_results.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (in_valid && in_ready) lex_predict(in_item);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, value", out_item.value, 8'h00);
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind != want.kind)
            report_mismatch("kind", {6'd0, out_item.kind}, {6'd0, want.kind});
          if (out_item.value != want.value)
            report_mismatch("value", out_item.value, want.value);
          if (out_item.last != want.last)
            report_mismatch("last", {7'd0, out_item.last}, {7'd0, want.last});
        end
        checked++;
      end
    end
    fail_count   <= mismatches;
    outstanding  <= expected_results.size();
    results_seen <= checked;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Top of the tokenizer bench. It only makes stimulus and gives the verdict;
// prediction and comparison live in ict_checker.
module tb import ict_pkg::*; ();

  localparam int HOLD_CYCLES = 300;   // long output hold-off, fills the queue
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 20;    // settle time after the last result
  localparam int PHASE_ITEMS = 82;    // least number of random bytes per idling mix

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int    fail_count;
  int    outstanding;
  int    results_seen;
  int    send_idle_pct;
  int    recv_idle_pct;
  int    bytes_sent;
  int    stall_cycles;
  int    holds_done;
  bit    hold_req;
  string word_set;
  string mark_set;

  idl_char_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  ict_checker lex_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One input transfer. Idle cycles come first, decided one cycle at a time;
  // with no idle cycle valid stays high straight into the next byte.
  task automatic send_item(logic [7:0] c, logic e);
    in_item_t nxt;
    nxt.ch           = c;
    nxt.end_of_input = e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= nxt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_word_char();
    return word_set[$urandom_range(0, word_set.len() - 1)];
  endfunction

  // One well-formed fragment of text with random content, or noise.
  // Weights lean on words, marks and strings so the deeper modes get hit.
  task automatic send_snippet();
    int         r;
    int         n;
    int         p;
    logic [7:0] q;
    r = $urandom_range(99);
    if (r < 30) begin
      // identifier or number, sometimes a directive name
      if ($urandom_range(3) == 0) send_item(CH_HASH, 1'b0);
      n = $urandom_range(1, 6);
      repeat (n) send_item(pick_word_char(), 1'b0);
    end else if (r < 42) begin
      send_item(mark_set[$urandom_range(0, mark_set.len() - 1)], 1'b0);
    end else if (r < 48) begin
      // scope operator or a lone colon
      send_item(CH_COLON, 1'b0);
      if ($urandom_range(1) == 0) send_item(CH_COLON, 1'b0);
    end else if (r < 58) begin
      // quoted string: escapes, raw bytes of any value, mostly closed
      q = ($urandom_range(1) == 0) ? CH_DQUOTE : CH_SQUOTE;
      send_item(q, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        p = $urandom_range(9);
        if (p < 2) begin
          send_item(CH_BSLASH, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (p < 4) begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_item(($urandom_range(4) == 0) ? CH_SPACE : pick_word_char(), 1'b0);
        end
      end
      if ($urandom_range(9) != 0) send_item(q, 1'b0);
    end else if (r < 64) begin
      // line comment, body of random bytes, ended by CR or LF
      send_item(CH_SLASH, 1'b0);
      send_item(CH_SLASH, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(($urandom_range(1) == 0) ? CH_LF : CH_CR, 1'b0);
    end else if (r < 68) begin
      // backslash skip, ended by NUL, CR or LF
      send_item(CH_BSLASH, 1'b0);
      n = $urandom_range(0, 3);
      repeat (n) send_item(pick_word_char(), 1'b0);
      p = $urandom_range(2);
      send_item((p == 0) ? CH_NUL : (p == 1) ? CH_CR : CH_LF, 1'b0);
    end else if (r < 73) begin
      send_item(CH_SLASH, 1'b0);
    end else if (r < 85) begin
      p = $urandom_range(4);
      case (p)
        0:       send_item(CH_SPACE, 1'b0);
        1:       send_item(CH_TAB, 1'b0);
        2:       send_item(CH_CR, 1'b0);
        3:       send_item(CH_LF, 1'b0);
        default: send_item(CH_NUL, 1'b0);
      endcase
    end else if (r < 93) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // flush; ch carries junk that must be ignored
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Receiver: random ready, plus one long hold-off when asked for, timed
  // here so the sender keeps offering bytes while the queue backs up.
  initial begin
    out_ready  = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req && holds_done == 0) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done = 1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: only cycles with no transfer at all count toward the limit
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still pending",
               STALL_LIMIT, outstanding);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int target;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    send_idle_pct = 9;
    recv_idle_pct = 67;
    word_set      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    mark_set      = "*;,.={}[]><()+&|!-";
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: hashed word with digit and underscore, "::" then a lone ':',
    // held slash followed by a letter, high bytes as errors, escaped quote
    // in a string, comment carrying a NUL, backslash skip ended by NUL,
    // flush after a lone slash, flush in an open string, flush while idle.
    send_text("#a_9:::;/x");
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("\"\\\"\"");
    send_text("//");
    send_item(CH_NUL, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("\\q");
    send_item(CH_NUL, 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(CH_SQUOTE, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hA5, 1'b1);

    // mix 1: sender mostly busy, receiver mostly idle
    target = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < target) send_snippet();

    // mix 2: the other way round
    send_idle_pct = 67;
    recv_idle_pct <= 9;
    target = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < target) send_snippet();

    // mix 3: no idling, with the long output hold-off at its start
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req      <= 1'b1;
    target = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < target) send_snippet();
    send_item(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input bytes: directed edge cases, then random text under",
             bytes_sent);
    $display("three idling mixes and one %0d-cycle output hold-off; %0d results compared",
             HOLD_CYCLES, results_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
